@@ hw/rtl/nau_pkg.sv @@
`default_nettype none
package nau_pkg;
    localparam int FRAC_BITS = 12;
    localparam int DATA_W    = 16;
    localparam int EXP_MAX_N = 40;
    localparam int DIV_STAGES = 32;

    typedef enum logic [2:0] {
        FN_IDENT   = 3'd0,
        FN_LOGI    = 3'd1,
        FN_TANH    = 3'd2,
        FN_RELU    = 3'd3,
        FN_STEEP   = 3'd4,
        FN_REEXP   = 3'd5,
        FN_SHIFT   = 3'd6,
        FN_RSVD    = 3'd7
    } fn_sel_t;

    typedef enum logic [1:0] {
        PP_PASS   = 2'd0,
        PP_LOGI   = 2'd1,
        PP_TANH   = 2'd2,
        PP_REEXP  = 2'd3
    } post_op_t;

    // control carried alongside data through every cell
    typedef struct packed {
        logic      valid;
        post_op_t  op;
        logic      neg;
        logic      zero;
        logic [DATA_W-1:0] raw;
    } nau_ctl_t;

    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [34:0] SLOPE_Q32 = 35'd21149591492;
endpackage
`default_nettype wire

@@ hw/rtl/nau_div_cell.sv @@
`default_nettype none
module nau_div_cell (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire nau_pkg::nau_ctl_t    ctl_in,
    input  wire logic [33:0]          rem_in,
    input  wire logic [33:0]          den_in,
    input  wire logic [62:0]          num_in,
    input  wire logic [31:0]          quo_in,
    output nau_pkg::nau_ctl_t         ctl_out,
    output logic [33:0]               rem_out,
    output logic [33:0]               den_out,
    output logic [62:0]               num_out,
    output logic [31:0]               quo_out
);
    import nau_pkg::*;

    // one restoring-division bit per cell
    logic [34:0] trial;
    logic        fits;
    logic [33:0] rem_next;
    nau_ctl_t    ctl_reg;
    logic [33:0] rem_reg, den_reg;
    logic [62:0] num_reg;
    logic [31:0] quo_reg;

    always_comb begin
        trial    = {rem_in, num_in[62]};
        fits     = trial >= {1'b0, den_in};
        rem_next = fits ? 34'(trial - {1'b0, den_in}) : trial[33:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_reg <= ctl_in;
            rem_reg <= rem_next;
            den_reg <= den_in;
            num_reg <= {num_in[61:0], 1'b0};
            quo_reg <= {quo_in[30:0], fits};
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign num_out = num_reg;
    assign quo_out = quo_reg;
endmodule
`default_nettype wire

@@ hw/rtl/nau_exp_cell.sv @@
`default_nettype none
module nau_exp_cell (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic [4:0]           k,
    input  wire logic [37:0]          recip,
    input  wire nau_pkg::nau_ctl_t    ctl_in,
    input  wire logic [31:0]          r_in,
    input  wire logic [32:0]          term_in,
    input  wire logic [33:0]          sum_in,
    output nau_pkg::nau_ctl_t         ctl_out,
    output logic [31:0]               r_out,
    output logic [32:0]               term_out,
    output logic [33:0]               sum_out
);
    import nau_pkg::*;

    // one taylor term over two stages: term = ((term*r)>>32)/k, alternating sign
    // first stage forms the product, second divides by k through
    // ceil(2^37/k), exact for a 32-bit dividend
    logic [63:0] prod;
    logic [69:0] qprod;
    logic [32:0] tnext;
    logic [33:0] snext;
    nau_ctl_t    ctla_reg;
    logic [31:0] ra_reg;
    logic [31:0] pq_reg;
    logic [33:0] suma_reg;
    nau_ctl_t    ctl_reg;
    logic [31:0] r_reg;
    logic [32:0] term_reg;
    logic [33:0] sum_reg;

    always_comb begin
        prod = 64'(term_in) * 64'(r_in);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctla_reg.valid <= 1'b0;
        end else if (en) begin
            ctla_reg <= ctl_in;
            ra_reg   <= r_in;
            pq_reg   <= prod[63:32];
            suma_reg <= sum_in;
        end
    end

    always_comb begin
        qprod = 70'(pq_reg) * 70'(recip);
        tnext = qprod[69:37];
        if (k[0]) snext = 34'(suma_reg - {1'b0, tnext});
        else      snext = 34'(suma_reg + {1'b0, tnext});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_reg  <= ctla_reg;
            r_reg    <= ra_reg;
            term_reg <= tnext;
            sum_reg  <= snext;
        end
    end

    assign ctl_out  = ctl_reg;
    assign r_out    = r_reg;
    assign term_out = term_reg;
    assign sum_out  = sum_reg;
endmodule
`default_nettype wire

@@ hw/rtl/neural_activation_unit.sv @@
// channel  | ports                          | beat contents
// config   | psel penable pwrite paddr ... | reg 0 main_function, reg 1 gate_function
// input    | s_tvalid s_tready s_tdata     | tdata[15:0] x_value
//          | s_tuser                       | tuser[0] req_type
// result   | m_tvalid m_tready m_tdata     | tdata[15:0] y_value
// one beat per cycle while the result is not stalled; an accepted beat passes
// through the chain of registers into the output register
// (3 front stages, 20 taylor cells of 2 stages, 32 divider cells, output register)
// reset is synchronous active low and clears valids and both selectors
// a stall at the result holds the whole chain; a full output stage
// still takes a beat when the chain can advance
`default_nettype none
module neural_activation_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] x_value
    input  wire logic        s_tuser,   // [0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [15:0] y_value
);
    import nau_pkg::*;

    localparam int NT = 20;

    fn_sel_t main_fn_reg, gate_fn_reg;
    logic    en;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_fn_reg <= FN_IDENT;
            gate_fn_reg <= FN_IDENT;
        end else if (psel && penable && pwrite) begin
            if (paddr == 3'd0) main_fn_reg <= fn_sel_t'(pwdata[2:0]);
            if (paddr == 3'd4) gate_fn_reg <= fn_sel_t'(pwdata[2:0]);
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr == 3'd0) prdata = {29'd0, main_fn_reg};
        else if (paddr == 3'd4) prdata = {29'd0, gate_fn_reg};
    end

    // front stage 1: argument magnitude in q32 and post operation
    fn_sel_t  sel;
    logic signed [15:0] xs;
    logic     xneg;
    logic [15:0] xmag;
    logic [37:0] arg_next;
    nau_ctl_t ctl_next;
    logic signed [37:0] zq;

    assign s_tready = en;

    always_comb begin
        sel  = s_tuser ? gate_fn_reg : main_fn_reg;
        xs   = signed'(s_tdata);
        xneg = xs[15];
        xmag = xneg ? 16'(-xs) : 16'(xs);
        zq   = 38'(((38'(xs) <<< (32 - FRAC_BITS)) - 38'sh2_0000_0000) * 2);
        ctl_next.valid = s_tvalid;
        ctl_next.raw   = s_tdata;
        ctl_next.neg   = xneg;
        ctl_next.zero  = (xmag == 16'd0);
        arg_next = 38'({xmag, 20'd0});
        unique case (sel)
            FN_LOGI:  begin ctl_next.op = PP_LOGI; end
            FN_TANH:  begin ctl_next.op = PP_TANH; arg_next = 38'({xmag, 21'd0}); end
            FN_STEEP: begin ctl_next.op = PP_LOGI; arg_next = 38'd0; end
            FN_REEXP: begin ctl_next.op = PP_REEXP; end
            FN_SHIFT: begin
                ctl_next.op  = PP_LOGI;
                ctl_next.neg = zq[37];
                arg_next     = zq[37] ? 38'(-zq) : 38'(zq);
            end
            FN_RELU:  begin
                ctl_next.op  = PP_PASS;
                ctl_next.raw = xneg ? 16'd0 : s_tdata;
            end
            default:  begin ctl_next.op = PP_PASS; end
        endcase
    end

    // stage 1 register; steep slope product finished in stage 1b
    nau_ctl_t  c1_reg;
    logic [37:0] a1_reg;
    logic [15:0] m1_reg;
    logic        st1_reg;
    logic [50:0] sprod;
    logic [37:0] a1b;

    always_ff @(posedge aclk) begin
        if (!aresetn) c1_reg.valid <= 1'b0;
        else if (en) begin
            c1_reg  <= ctl_next;
            a1_reg  <= arg_next;
            m1_reg  <= xmag;
            st1_reg <= (sel == FN_STEEP);
        end
    end

    always_comb begin
        sprod = 51'(m1_reg) * 51'(SLOPE_Q32);
        a1b   = st1_reg ? 38'(sprod >> FRAC_BITS) : a1_reg;
    end

    // stage 2: range reduction by ln2 against a table of its multiples
    nau_ctl_t    c2_reg;
    logic [37:0] a2_reg;
    logic [5:0]  n_est;
    logic [37:0] nl;
    logic [31:0] r_red;

    always_ff @(posedge aclk) begin
        if (!aresetn) c2_reg.valid <= 1'b0;
        else if (en) begin
            c2_reg <= c1_reg;
            a2_reg <= a1b;
        end
    end

    // largest multiple of ln2 not above the argument, capped at the cutoff
    always_comb begin
        n_est = 6'd0;
        nl    = 38'd0;
        for (int j = 1; j <= EXP_MAX_N; j++) begin
            if (a2_reg >= 38'(j) * 38'(LN2_Q32)) begin
                n_est = 6'(j);
                nl    = 38'(j) * 38'(LN2_Q32);
            end
        end
        r_red = 32'(a2_reg - nl);
    end

    // stage 3: reduced argument and shift count
    nau_ctl_t    c3_reg;
    logic [5:0]  n3_reg;
    logic [31:0] r3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) c3_reg.valid <= 1'b0;
        else if (en) begin
            c3_reg <= c2_reg;
            n3_reg <= n_est;
            r3_reg <= r_red;
        end
    end

    // taylor chain
    nau_ctl_t    tc [NT+1];
    logic [31:0] tr [NT+1];
    logic [32:0] tt [NT+1];
    logic [33:0] ts [NT+1];
    logic [5:0]  tn [NT+1];

    assign tc[0] = c3_reg;
    assign tr[0] = r3_reg;
    assign tt[0] = 33'h1_0000_0000;
    assign ts[0] = 34'h1_0000_0000;
    assign tn[0] = n3_reg;

    for (genvar g = 0; g < NT; g++) begin : g_taylor
        localparam logic [37:0] RCP = 38'(((64'd1 << 37) + 64'(g)) / 64'(g + 1));
        logic [5:0] na_reg, n_reg;
        nau_exp_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en), .k(5'(g + 1)), .recip(RCP),
            .ctl_in(tc[g]), .r_in(tr[g]), .term_in(tt[g]), .sum_in(ts[g]),
            .ctl_out(tc[g+1]), .r_out(tr[g+1]), .term_out(tt[g+1]), .sum_out(ts[g+1])
        );
        always_ff @(posedge aclk) begin
            if (en) begin
                na_reg <= tn[g];
                n_reg  <= na_reg;
            end
        end
        assign tn[g+1] = n_reg;
    end

    // e value
    logic [32:0] ev;
    always_comb begin
        if (tn[NT] >= 6'(EXP_MAX_N) || ts[NT][33]) ev = 33'd0;
        else ev = 33'(ts[NT] >> tn[NT]);
    end

    // divider chain: floor(e*2^31/(2^32+e))
    nau_ctl_t    dc [DIV_STAGES+1];
    logic [33:0] dr [DIV_STAGES+1];
    logic [33:0] dd [DIV_STAGES+1];
    logic [62:0] dn [DIV_STAGES+1];
    logic [31:0] dq [DIV_STAGES+1];
    logic [32:0] de [DIV_STAGES+1];

    assign dc[0] = tc[NT];
    assign dd[0] = 34'h1_0000_0000 + 34'(ev);
    // numerator e<<31 is 64 bits; its upper 32 bits are below the divisor,
    // so they seed the remainder and the cells work through the lower 32
    assign dr[0] = 34'(ev >> 1);
    assign dn[0] = {ev[0], 62'd0};
    assign dq[0] = 32'd0;
    assign de[0] = ev;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        logic [32:0] e_reg;
        nau_div_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .ctl_in(dc[g]), .rem_in(dr[g]), .den_in(dd[g]), .num_in(dn[g]), .quo_in(dq[g]),
            .ctl_out(dc[g+1]), .rem_out(dr[g+1]), .den_out(dd[g+1]),
            .num_out(dn[g+1]), .quo_out(dq[g+1])
        );
        always_ff @(posedge aclk) if (en) e_reg <= de[g];
        assign de[g+1] = e_reg;
    end

    // post: select result, round, saturate
    nau_ctl_t    cf;
    logic [32:0] s, mag;
    logic        oneg;
    logic [33:0] rnd;
    logic [21:0] r16;
    logic [15:0] yv;

    always_comb begin
        cf   = dc[DIV_STAGES];
        s    = {dq[DIV_STAGES], 1'b0};
        oneg = 1'b0;
        unique case (cf.op)
            PP_LOGI:  mag = cf.neg ? s : 33'(34'h1_0000_0000 - 34'(s));
            PP_TANH:  begin mag = 33'(34'h1_0000_0000 - 34'({s, 1'b0})); oneg = cf.neg; end
            PP_REEXP: mag = 33'(34'h1_0000_0000 - 34'(de[DIV_STAGES]));
            default:  mag = 33'd0;
        endcase
        rnd = 34'(mag) + 34'(1 << (31 - FRAC_BITS));
        r16 = 22'(rnd >> (32 - FRAC_BITS));
        if (r16 > 22'd32768) r16 = 22'd32768;
        if (oneg) yv = 16'(-r16);
        else yv = (r16 > 22'd32767) ? 16'h7fff : 16'(r16);
        if (cf.op == PP_PASS) yv = cf.raw;
        if (cf.op == PP_REEXP && (cf.neg || cf.zero)) yv = 16'd0;
    end

    // output register
    logic        mv_reg;
    logic [15:0] md_reg;
    assign en = !mv_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) mv_reg <= 1'b0;
        else if (en) begin
            mv_reg <= cf.valid;
            md_reg <= yv;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready not tied to output stage");
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> $stable(c1_reg.valid))
        else $error("chain moved while stalled");
`endif
endmodule
`default_nettype wire
